// ===== design/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, register indexes, reset values and bundle types of the
// pure pursuit step block.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int COORD_W     = 24;
    localparam int FRAC_BITS   = 8;
    localparam int CATCH_UNITS = 10;
    localparam logic [COORD_W-1:0] CATCH_RESET = COORD_W'(CATCH_UNITS << FRAC_BITS);

    // Magnitude of a coordinate difference, its square and the shared unit width
    localparam int MAG_W  = COORD_W + 1;
    localparam int DATA_W = 2 * MAG_W;
    // Quotient and root bits produced one per iteration
    localparam int ROOT_W = COORD_W + 1;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int SUM_W  = COORD_W + 3;

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_START_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPEED   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CATCH   = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] speed;
        logic [COORD_W-1:0] catch_dist;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] fighter_x;
        logic [COORD_W-1:0] fighter_y;
        logic [COORD_W-1:0] distance;
        logic               caught;
    } result_t;

endpackage

// ===== design/pure_pursuit_step.sv =====
`timescale 1ns / 1ps
// A first or non-moving item runs the squared distance and square root; a
// moving one runs the move first; one after a catch skips both. Items go
// one at a time: a new item is taken only while the core is idle. The
// 25-step divider (once per axis) and 25-step square root share one subtractor.
// Reset: synchronous, active low; clears pursuit state, sets registers to
// their defaults (catch distance 10.0) and drops the output valid.
// ----------------------------------------------------------------------------
// pure_pursuit_step
// Fighter pursuit step: moves the fighter toward the previous bomber
// position, reports position, distance and a sticky caught flag per item.
// ----------------------------------------------------------------------------
module pure_pursuit_step
    import pps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_addr,
    input  logic [COORD_W-1:0]   cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [COORD_W-1:0]   s_bomber_x,
    input  logic [COORD_W-1:0]   s_bomber_y,
    input  logic                 s_first_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COORD_W-1:0]   m_fighter_x,
    output logic [COORD_W-1:0]   m_fighter_y,
    output logic [COORD_W-1:0]   m_distance,
    output logic                 m_caught
);

    cfg_t    cfg_reg, cfg_next;
    logic    m_valid_reg, m_valid_next;
    result_t out_reg, out_next;
    logic    core_ready, core_done, out_free;
    result_t core_res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_START_X: cfg_next.start_x    = cfg_wr_data;
                REG_START_Y: cfg_next.start_y    = cfg_wr_data;
                REG_SPEED:   cfg_next.speed      = cfg_wr_data;
                REG_CATCH:   cfg_next.catch_dist = cfg_wr_data;
                default:     cfg_next            = cfg_reg;
            endcase
        end
    end

    assign out_free = ~m_valid_reg | m_ready;

    pps_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid & core_ready),
        .in_bx    (s_bomber_x),
        .in_by    (s_bomber_y),
        .in_first (s_first_sample),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .ready    (core_ready),
        .done     (core_done),
        .res      (core_res)
    );

    // Load a finished item into the output slot, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (core_done && out_free) begin
            m_valid_next = 1'b1;
            out_next     = core_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '{start_x: '0, start_y: '0, speed: '0, catch_dist: CATCH_RESET};
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign s_ready     = core_ready;
    assign m_valid     = m_valid_reg;
    assign m_fighter_x = out_reg.fighter_x;
    assign m_fighter_y = out_reg.fighter_y;
    assign m_distance  = out_reg.distance;
    assign m_caught    = out_reg.caught;

endmodule

// ===== design/pps_sub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_sub
// Shared compare-subtract unit: one trial subtraction per cycle for the
// restoring divider and the digit-by-digit square root.
// ----------------------------------------------------------------------------
module pps_sub
    import pps_pkg::*;
(
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] diff,
    output logic              ge
);

    logic [DATA_W:0] wide_diff;

    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign diff      = wide_diff[DATA_W-1:0];
    assign ge        = ~wide_diff[DATA_W];

endmodule

// ===== design/pps_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_core
// Step sequencer: holds the pursuit state and runs the move (multiply and
// divide per axis), the squared distance and the square root through one
// multiplier and the shared compare-subtract unit.
// ----------------------------------------------------------------------------
module pps_core
    import pps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [COORD_W-1:0] in_bx,
    input  logic [COORD_W-1:0] in_by,
    input  logic               in_first,
    input  cfg_t               cfg,
    input  logic               out_free,
    output logic               ready,
    output logic               done,
    output result_t            res
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MULX,
        ST_DIVX,
        ST_UPDX,
        ST_MULY,
        ST_DIVY,
        ST_UPDY,
        ST_SQX,
        ST_SQY,
        ST_SQADD,
        ST_ROOT,
        ST_SETTLE,
        ST_DONE
    } state_t;

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((1 << (COORD_W-1)) - 1);
    localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(1 << (COORD_W-1));

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] pos_x_reg, pos_x_next;
    logic [COORD_W-1:0] pos_y_reg, pos_y_next;
    logic [COORD_W-1:0] lbx_reg, lbx_next;
    logic [COORD_W-1:0] lby_reg, lby_next;
    logic [COORD_W-1:0] ldist_reg, ldist_next;
    logic               caught_reg, caught_next;
    logic [COORD_W-1:0] bx_reg, bx_next;
    logic [COORD_W-1:0] by_reg, by_next;
    logic               first_reg, first_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic [DATA_W-1:0]  aux_reg, aux_next;
    logic [ROOT_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;

    logic [COORD_W-1:0]      da, db;
    logic signed [MAG_W-1:0] delta;
    logic [MAG_W-1:0]        delta_mag;
    logic [MAG_W-1:0]        mul_a;
    logic [DATA_W-1:0]       product;
    logic [DATA_W-1:0]       sub_a, sub_b, sub_diff;
    logic                    sub_ge;
    logic [COORD_W-1:0]      upd_pos;
    logic signed [SUM_W-1:0] step, sum;
    logic [COORD_W-1:0]      sat_pos;
    logic                    caught_now;
    logic [COORD_W-1:0]      dist_sat;
    logic                    last_iter;

    // Difference of coordinates for the current phase
    always_comb begin
        case (state_reg)
            ST_MULY: begin
                da = lby_reg;
                db = pos_y_reg;
            end
            ST_SQX: begin
                da = bx_reg;
                db = pos_x_reg;
            end
            ST_SQY: begin
                da = by_reg;
                db = pos_y_reg;
            end
            default: begin
                da = lbx_reg;
                db = pos_x_reg;
            end
        endcase
    end

    assign delta     = $signed({da[COORD_W-1], da}) - $signed({db[COORD_W-1], db});
    assign delta_mag = delta[MAG_W-1] ? (~delta + 1'b1) : delta;

    assign mul_a   = (state_reg inside {ST_SQX, ST_SQY}) ? delta_mag : {1'b0, cfg.speed};
    assign product = {{MAG_W{1'b0}}, mul_a} * {{MAG_W{1'b0}}, delta_mag};

    always_comb begin
        if (state_reg == ST_ROOT) begin
            sub_a = {acc_reg[DATA_W-3:0], aux_reg[DATA_W-1 -: 2]};
            sub_b = DATA_W'({quo_reg, 2'b01});
        end else begin
            sub_a = acc_reg;
            sub_b = aux_reg;
        end
    end

    pps_sub u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    assign upd_pos = (state_reg == ST_UPDY) ? pos_y_reg : pos_x_reg;
    assign step    = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign sum     = $signed({{3{upd_pos[COORD_W-1]}}, upd_pos}) + step;

    always_comb begin
        if (sum > POS_MAX) begin
            sat_pos = POS_MAX[COORD_W-1:0];
        end else if (sum < POS_MIN) begin
            sat_pos = POS_MIN[COORD_W-1:0];
        end else begin
            sat_pos = sum[COORD_W-1:0];
        end
    end

    assign caught_now = (quo_reg <= {1'b0, cfg.catch_dist});
    assign dist_sat   = quo_reg[ROOT_W-1] ? '1 : quo_reg[COORD_W-1:0];
    assign last_iter  = (cnt_reg == CNT_W'(ROOT_W - 1));

    always_comb begin
        state_next  = state_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        lbx_next    = lbx_reg;
        lby_next    = lby_reg;
        ldist_next  = ldist_reg;
        caught_next = caught_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        first_next  = first_reg;
        acc_next    = acc_reg;
        aux_next    = aux_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    bx_next    = in_bx;
                    by_next    = in_by;
                    first_next = in_first;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (first_reg) begin
                    pos_x_next  = cfg.start_x;
                    pos_y_next  = cfg.start_y;
                    caught_next = 1'b0;
                    state_next  = ST_SQX;
                end else if (caught_reg) begin
                    state_next = ST_DONE;
                end else if (ldist_reg == '0) begin
                    state_next = ST_SQX;
                end else begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX, ST_MULY: begin
                acc_next   = product;
                neg_next   = delta[MAG_W-1];
                aux_next   = DATA_W'(ldist_reg) << (ROOT_W - 1);
                quo_next   = '0;
                cnt_next   = '0;
                state_next = (state_reg == ST_MULX) ? ST_DIVX : ST_DIVY;
            end
            ST_DIVX, ST_DIVY: begin
                if (sub_ge) begin
                    acc_next = sub_diff;
                end
                quo_next = {quo_reg[ROOT_W-2:0], sub_ge};
                aux_next = aux_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (last_iter) begin
                    state_next = (state_reg == ST_DIVX) ? ST_UPDX : ST_UPDY;
                end
            end
            ST_UPDX: begin
                pos_x_next = sat_pos;
                state_next = ST_MULY;
            end
            ST_UPDY: begin
                pos_y_next = sat_pos;
                state_next = ST_SQX;
            end
            ST_SQX: begin
                acc_next   = product;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                aux_next   = product;
                state_next = ST_SQADD;
            end
            ST_SQADD: begin
                aux_next   = acc_reg + aux_reg;
                acc_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                acc_next = sub_ge ? sub_diff : sub_a;
                quo_next = {quo_reg[ROOT_W-2:0], sub_ge};
                aux_next = aux_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (last_iter) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                ldist_next  = dist_sat;
                lbx_next    = bx_reg;
                lby_next    = by_reg;
                caught_next = caught_now;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            lbx_reg    <= '0;
            lby_reg    <= '0;
            ldist_reg  <= '0;
            caught_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            lbx_reg    <= lbx_next;
            lby_reg    <= lby_next;
            ldist_reg  <= ldist_next;
            caught_reg <= caught_next;
            cnt_reg    <= cnt_next;
        end
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        first_reg <= first_next;
        acc_reg   <= acc_next;
        aux_reg   <= aux_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
    end

    assign ready = (state_reg == ST_IDLE);
    assign done  = (state_reg == ST_DONE);
    assign res   = '{fighter_x: pos_x_reg, fighter_y: pos_y_reg,
                     distance: ldist_reg, caught: caught_reg};

endmodule

// ===== design/pps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the pure pursuit step block, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker
    import pps_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COORD_W-1:0] m_fighter_x,
    input logic [COORD_W-1:0] m_distance,
    input logic               m_caught
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid not cleared by reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in work");

    a_zero_dist_caught: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_distance == '0) |-> m_caught)
        else $error("zero distance without caught flag");

    a_new_item_from_core: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result item appeared while idle");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fighter_x) && $stable(m_distance))
        else $error("stalled result item changed");

endmodule

bind pure_pursuit_step pps_checker u_pps_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_fighter_x (m_fighter_x),
    .m_distance  (m_distance),
    .m_caught    (m_caught)
);
